// ===== design/assert_macros.svh =====
// Assertion macros for the design files; the top module includes them.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mhme_pkg.sv =====
package mhme_pkg;

    localparam int WORD_W      = 64;
    localparam int INDEX_W     = 17;
    localparam int RAW_ADDR_W  = 32;
    localparam int SIZE_LOG2_W = 5;

    localparam logic [SIZE_LOG2_W-1:0] SIZE_LOG2_RESET = 5'd17;

    localparam logic [RAW_ADDR_W-1:0] KEY_XOR      = 32'h0a1b2c3d;
    localparam logic [RAW_ADDR_W-1:0] KEY_PAIR     = 32'hfedc0123;
    localparam logic [RAW_ADDR_W-1:0] KEY_INDIRECT = 32'h76543210;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_SET_CARRY = 2'd1,
        CMD_MIX       = 2'd2,
        CMD_READ      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        BR_ADD      = 2'd0,
        BR_XOR      = 2'd1,
        BR_PAIR     = 2'd2,
        BR_INDIRECT = 2'd3
    } t_branch;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_OUT  = 7'b0000010,
        S_UPD1 = 7'b0000100,
        S_RD_B = 7'b0001000,
        S_UPD2 = 7'b0010000,
        S_RD_C = 7'b0100000,
        S_FIN  = 7'b1000000
    } t_state;

    function automatic logic [RAW_ADDR_W-1:0] branch_key(input t_branch br);
        logic [RAW_ADDR_W-1:0] key;
        case (br)
            BR_ADD:      key = '0;
            BR_XOR:      key = KEY_XOR;
            BR_PAIR:     key = KEY_PAIR;
            BR_INDIRECT: key = KEY_INDIRECT;
            default:     key = '0;
        endcase
        return key;
    endfunction

endpackage

// ===== design/memory_hard_mix_engine_top.sv =====
// Mixing core for a memory-hard hash: a store of 2^ADDR_BITS 64-bit words in one
// synchronous RAM with a single write and a single read port, plus a 64-bit carry.
// All work is ordered through that RAM, with a shared 64-bit add/XOR unit, so an
// input transaction occupies the block until it is back in S_IDLE: load word and
// set carry finish there, read word passes through S_OUT (and waits there while a
// previous result is still held by the output stall), mix branch 0 and 1 use S_UPD1,
// branch 3 uses S_UPD1, S_UPD2, S_RD_C, S_FIN and branch 2 S_UPD1, S_RD_B, S_UPD2,
// S_RD_C, S_FIN. RAM reads are registered, and every dependent read waits for the
// previous write. The size register may be written at any time the block is idle
// and is always ready. Words must be loaded before a read or a mix step uses them.
`include "assert_macros.svh"

module memory_hard_mix_engine_top
    import mhme_pkg::*;
#(
    parameter int ADDR_BITS = 17
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_command,
    input  logic [INDEX_W-1:0]     i_word_index,
    input  logic [WORD_W-1:0]      i_word_value,
    input  logic [1:0]             i_branch,
    input  logic [RAW_ADDR_W-1:0]  i_addr_first,
    input  logic [RAW_ADDR_W-1:0]  i_addr_second,
    input  logic [WORD_W-1:0]      i_value_first,
    input  logic [WORD_W-1:0]      i_value_second,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [WORD_W-1:0]      o_read_data,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [SIZE_LOG2_W-1:0] i_cfg_data
);

    t_state                 r_state, n_state;
    logic [WORD_W-1:0]      r_carry, n_carry;
    logic [SIZE_LOG2_W-1:0] r_size_log2;
    t_branch                r_br;
    logic [ADDR_BITS-1:0]   r_a;
    logic [ADDR_BITS-1:0]   r_b, n_b;
    logic [WORD_W-1:0]      r_va, r_vb;
    logic                   r_out_valid;
    logic [WORD_W-1:0]      r_read_data;

    logic                   in_acc;
    t_cmd                   in_cmd;
    t_branch                in_br;
    logic [ADDR_BITS-1:0]   mask;
    logic [RAW_ADDR_W-1:0]  a_raw, b_raw;
    logic [ADDR_BITS-1:0]   a_in, b_in, idx_in;

    logic                   ram_we, ram_re;
    logic [ADDR_BITS-1:0]   ram_waddr, ram_raddr;
    logic [WORD_W-1:0]      ram_wdata, rd;

    logic [WORD_W-1:0]      alu_x, alu_y, alu_res;
    logic                   alu_add;
    logic                   capture;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign in_cmd      = t_cmd'(i_command);
    assign in_br       = t_branch'(i_branch);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_read_data;

    // Mask bit i is set when i is below the configured size; sizes past
    // ADDR_BITS therefore saturate to a full mask.
    always_comb begin
        for (int i = 0; i < ADDR_BITS; i++) begin
            mask[i] = (r_size_log2 > SIZE_LOG2_W'(i));
        end
    end

    assign a_raw  = i_addr_first ^ branch_key(in_br);
    assign b_raw  = i_addr_second ^ KEY_PAIR;
    assign a_in   = a_raw[ADDR_BITS-1:0] & mask;
    assign b_in   = b_raw[ADDR_BITS-1:0] & mask;
    assign idx_in = ADDR_BITS'(i_word_index);

    // Shared 64-bit unit: wrapping add or XOR.
    assign alu_res = alu_add ? (alu_x + alu_y) : (alu_x ^ alu_y);

    always_comb begin
        n_state   = r_state;
        n_carry   = r_carry;
        n_b       = r_b;
        ram_we    = 1'b0;
        ram_waddr = r_a;
        ram_wdata = alu_res;
        ram_re    = 1'b0;
        ram_raddr = r_a;
        alu_x     = rd;
        alu_y     = r_carry;
        alu_add   = 1'b0;
        capture   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (in_cmd)
                        CMD_LOAD: begin
                            ram_we    = 1'b1;
                            ram_waddr = idx_in;
                            ram_wdata = i_word_value;
                        end
                        CMD_SET_CARRY: begin
                            n_carry = i_word_value;
                        end
                        CMD_MIX: begin
                            ram_re    = 1'b1;
                            ram_raddr = a_in;
                            n_b       = b_in;
                            n_state   = S_UPD1;
                        end
                        CMD_READ: begin
                            ram_re    = 1'b1;
                            ram_raddr = idx_in;
                            n_state   = S_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUT: begin
                // The RAM read register holds its word until the output slot frees.
                if (!r_out_valid || !i_out_stall) begin
                    capture = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_UPD1: begin
                case (r_br)
                    BR_ADD: begin
                        alu_add = 1'b1;
                        ram_we  = 1'b1;
                        n_carry = r_carry ^ r_va;
                        n_state = S_IDLE;
                    end
                    BR_XOR: begin
                        alu_x     = r_carry;
                        alu_y     = r_va;
                        alu_add   = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = rd ^ r_carry;
                        n_carry   = alu_res;
                        n_state   = S_IDLE;
                    end
                    BR_PAIR: begin
                        alu_y   = r_va;
                        ram_we  = 1'b1;
                        n_state = S_RD_B;
                    end
                    BR_INDIRECT: begin
                        ram_re    = 1'b1;
                        ram_raddr = rd[ADDR_BITS-1:0] & mask;
                        n_b       = rd[ADDR_BITS-1:0] & mask;
                        n_state   = S_UPD2;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RD_B: begin
                ram_re    = 1'b1;
                ram_raddr = r_b;
                n_state   = S_UPD2;
            end
            S_UPD2: begin
                alu_y     = r_carry ^ ((r_br == BR_INDIRECT) ? r_va : r_vb);
                alu_add   = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = r_b;
                n_state   = S_RD_C;
            end
            S_RD_C: begin
                ram_re    = 1'b1;
                ram_raddr = (r_br == BR_PAIR) ? (r_carry[ADDR_BITS-1:0] & mask) : r_a;
                n_state   = S_FIN;
            end
            S_FIN: begin
                alu_x = r_carry;
                if (r_br == BR_PAIR) begin
                    alu_y = rd;
                end else begin
                    alu_y   = rd ^ r_vb;
                    alu_add = 1'b1;
                end
                n_carry = alu_res;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_carry     <= '0;
            r_size_log2 <= SIZE_LOG2_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_carry <= n_carry;
            if (i_cfg_valid) begin
                r_size_log2 <= i_cfg_data;
            end
            if (capture) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_br <= in_br;
            r_a  <= a_in;
            r_va <= i_value_first;
            r_vb <= i_value_second;
        end
        r_b <= n_b;
        if (capture) begin
            r_read_data <= rd;
        end
    end

    mhme_ram #(
        .WIDTH      (WORD_W),
        .DEPTH_LOG2 (ADDR_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    // The sequencer never reads a word in the cycle it is being written.
    `ASSERT_ALWAYS(a_no_rw_same_addr, !(ram_we && ram_re && (ram_waddr == ram_raddr)), "RAM read and write collide")
    // A mix transaction always starts with its first update step.
    `ASSERT_NEXT(a_mix_enters_upd1, in_acc && (in_cmd == CMD_MIX), r_state == S_UPD1, "mix did not start")
    // Only branch 2 reads a second address through S_RD_B.
    `ASSERT_SAME(a_rd_b_pair_only, r_state == S_RD_B, r_br == BR_PAIR, "second address read outside branch 2")
    // The final carry update always follows the dependent read.
    `ASSERT_SAME(a_fin_after_rd_c, r_state == S_FIN, $past(r_state) == S_RD_C, "carry update without its read")
    // A read result waits while the previous one is still stalled.
    `ASSERT_NEXT(a_out_hold, (r_state == S_OUT) && r_out_valid && i_out_stall, r_state == S_OUT, "result slot overwritten")

endmodule

// ===== design/mhme_ram.sv =====
module mhme_ram #(
    parameter int WIDTH      = 64,
    parameter int DEPTH_LOG2 = 17
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [DEPTH_LOG2-1:0] i_waddr,
    input  logic [WIDTH-1:0]      i_wdata,
    input  logic                  i_re,
    input  logic [DEPTH_LOG2-1:0] i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);

    localparam longint unsigned DEPTH = 64'd1 << DEPTH_LOG2;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== test/tb_memory_hard_mix_engine_top.sv =====
`timescale 1ns / 1ps

module tb_memory_hard_mix_engine_top;
    import mhme_pkg::*;

    localparam int ADDR_BITS   = 17;
    localparam int DEPTH       = 1 << ADDR_BITS;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 16;
    localparam int BURST_ITEMS = 125;

    localparam logic [RAW_ADDR_W-1:0] MIX_KEYS [4] = '{32'h0, KEY_XOR, KEY_PAIR, KEY_INDIRECT};

    typedef struct {
        t_cmd                  cmd;
        logic [INDEX_W-1:0]    index;
        logic [WORD_W-1:0]     value;
        t_branch               br;
        logic [RAW_ADDR_W-1:0] addr_a;
        logic [RAW_ADDR_W-1:0] addr_b;
        logic [WORD_W-1:0]     value_a;
        logic [WORD_W-1:0]     value_b;
    } t_mix_txn;

    // Shadow copy of the word store and carry; expected read data is queued in order.
    class mix_scoreboard;
        bit [WORD_W-1:0]      words [DEPTH];
        bit                   loaded [DEPTH];
        int                   loaded_list [$];
        bit [WORD_W-1:0]      carry;
        bit [SIZE_LOG2_W-1:0] size_log2;
        bit [WORD_W-1:0]      read_queue [$];
        int                   errors;

        function new();
            carry     = '0;
            size_log2 = SIZE_LOG2_RESET;
            errors    = 0;
        endfunction

        function logic [INDEX_W-1:0] mask();
            int e;
            e = (size_log2 > ADDR_BITS) ? ADDR_BITS : int'(size_log2);
            return INDEX_W'((32'd1 << e) - 1);
        endfunction

        function logic [INDEX_W-1:0] mix_addr(t_branch br, logic [RAW_ADDR_W-1:0] raw);
            return (raw[INDEX_W-1:0] ^ MIX_KEYS[br][INDEX_W-1:0]) & mask();
        endfunction

        function int pending();
            return read_queue.size();
        endfunction

        // First word that a mix step would read before anything has been loaded there.
        function int first_unloaded(t_branch br, logic [RAW_ADDR_W-1:0] ra,
                                    logic [RAW_ADDR_W-1:0] rb);
            logic [INDEX_W-1:0] a;
            logic [INDEX_W-1:0] b;
            logic [INDEX_W-1:0] t;
            a = mix_addr(br, ra);
            if (!loaded[a]) return int'(a);
            case (br)
                BR_PAIR: begin
                    b = mix_addr(br, rb);
                    if (!loaded[b]) return int'(b);
                    t = carry[INDEX_W-1:0] & mask();
                    if (!loaded[t]) return int'(t);
                end
                BR_INDIRECT: begin
                    t = words[a][INDEX_W-1:0] & mask();
                    if (!loaded[t]) return int'(t);
                end
                default: ;
            endcase
            return -1;
        endfunction

        function void note_input(t_mix_txn it);
            logic [INDEX_W-1:0] m;
            logic [INDEX_W-1:0] a;
            logic [INDEX_W-1:0] b;
            logic [INDEX_W-1:0] t;
            m = mask();
            a = mix_addr(it.br, it.addr_a);
            b = mix_addr(it.br, it.addr_b);
            case (it.cmd)
                CMD_LOAD: begin
                    words[it.index] = it.value;
                    if (!loaded[it.index]) begin
                        loaded[it.index] = 1'b1;
                        loaded_list.push_back(int'(it.index));
                    end
                end
                CMD_SET_CARRY: carry = it.value;
                CMD_MIX: begin
                    case (it.br)
                        BR_ADD: begin
                            words[a] += carry;
                            carry ^= it.value_a;
                        end
                        BR_XOR: begin
                            words[a] ^= carry;
                            carry += it.value_a;
                        end
                        BR_PAIR: begin
                            words[a] ^= it.value_a;
                            words[b] += it.value_b ^ carry;
                            carry ^= words[carry[INDEX_W-1:0] & m];
                        end
                        default: begin
                            // The carry update re-reads word a after the indirect write.
                            t = words[a][INDEX_W-1:0] & m;
                            words[t] += carry ^ it.value_a;
                            carry += words[a] ^ it.value_b;
                        end
                    endcase
                end
                default: read_queue.push_back(words[it.index]);
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [WORD_W-1:0] got);
            bit [WORD_W-1:0] want;
            if (read_queue.size() == 0) begin
                report_mismatch($sformatf("unexpected read_data %h", got));
            end else begin
                want = read_queue.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("read_data %h, expected %h", got, want));
            end
        endtask
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [1:0]             i_command;
    logic [INDEX_W-1:0]     i_word_index;
    logic [WORD_W-1:0]      i_word_value;
    logic [1:0]             i_branch;
    logic [RAW_ADDR_W-1:0]  i_addr_first;
    logic [RAW_ADDR_W-1:0]  i_addr_second;
    logic [WORD_W-1:0]      i_value_first;
    logic [WORD_W-1:0]      i_value_second;
    logic                   o_out_valid;
    logic                   i_out_stall = 1'b0;
    logic [WORD_W-1:0]      o_read_data;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [SIZE_LOG2_W-1:0] i_cfg_data;

    mix_scoreboard sb;
    bit            quiet = 1'b0;
    int unsigned   cycles = 0;

    memory_hard_mix_engine_top #(
        .ADDR_BITS(ADDR_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command      (i_command),
        .i_word_index   (i_word_index),
        .i_word_value   (i_word_value),
        .i_branch       (i_branch),
        .i_addr_first   (i_addr_first),
        .i_addr_second  (i_addr_second),
        .i_value_first  (i_value_first),
        .i_value_second (i_value_second),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= quiet ? 1'b0 : ($urandom_range(0, 99) < 25);
    end

    // Values sampled here are the ones present at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_read_data);
    end

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic t_mix_txn random_txn(t_cmd cmd);
        t_mix_txn it;
        it.cmd     = cmd;
        it.index   = INDEX_W'($urandom);
        it.value   = rand_word();
        it.br      = t_branch'($urandom_range(0, 3));
        it.addr_a  = $urandom;
        it.addr_b  = $urandom;
        it.value_a = rand_word();
        it.value_b = rand_word();
        return it;
    endfunction

    // Call it just after the clock rises; it returns in the time step in which the block takes the transaction.
    task automatic push_command(t_mix_txn it);
        if (!quiet) begin
            while ($urandom_range(0, 99) < 25) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid     <= 1'b1;
        i_command      <= it.cmd;
        i_word_index   <= it.index;
        i_word_value   <= it.value;
        i_branch       <= it.br;
        i_addr_first   <= it.addr_a;
        i_addr_second  <= it.addr_b;
        i_value_first  <= it.value_a;
        i_value_second <= it.value_b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(it);
    endtask

    task automatic push_load(logic [INDEX_W-1:0] idx, logic [WORD_W-1:0] val);
        t_mix_txn it;
        it       = random_txn(CMD_LOAD);
        it.index = idx;
        it.value = val;
        push_command(it);
    endtask

    task automatic push_carry(logic [WORD_W-1:0] val);
        t_mix_txn it;
        it       = random_txn(CMD_SET_CARRY);
        it.value = val;
        push_command(it);
    endtask

    task automatic push_read(logic [INDEX_W-1:0] idx);
        t_mix_txn it;
        if (!sb.loaded[idx])
            push_load(idx, rand_word());
        it       = random_txn(CMD_READ);
        it.index = idx;
        push_command(it);
    endtask

    // Loads every word the step would read that holds nothing yet, then sends the step.
    task automatic push_mix(t_branch br, logic [RAW_ADDR_W-1:0] ra, logic [RAW_ADDR_W-1:0] rb,
                            logic [WORD_W-1:0] va, logic [WORD_W-1:0] vb);
        t_mix_txn it;
        int       missing;
        missing = sb.first_unloaded(br, ra, rb);
        while (missing >= 0) begin
            push_load(INDEX_W'(missing), rand_word());
            missing = sb.first_unloaded(br, ra, rb);
        end
        it         = random_txn(CMD_MIX);
        it.br      = br;
        it.addr_a  = ra;
        it.addr_b  = rb;
        it.value_a = va;
        it.value_b = vb;
        push_command(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_size(logic [SIZE_LOG2_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        sb.size_log2 = val;
    endtask

    // Raw address whose key-mixed low bits, before masking, name a word that already holds data, upper bits random.
    function automatic logic [RAW_ADDR_W-1:0] aim_addr(t_branch br);
        logic [RAW_ADDR_W-1:0] raw;
        logic [INDEX_W-1:0]    tgt;
        raw = $urandom;
        tgt = INDEX_W'(sb.loaded_list[$urandom_range(0, sb.loaded_list.size() - 1)]);
        raw[INDEX_W-1:0] = tgt ^ MIX_KEYS[br][INDEX_W-1:0];
        return raw;
    endfunction

    task automatic random_burst(int count);
        int                    pick;
        t_branch               br;
        logic [RAW_ADDR_W-1:0] ra;
        logic [RAW_ADDR_W-1:0] rb;
        logic [INDEX_W-1:0]    idx;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                idx = ($urandom_range(0, 99) < 70) ? (INDEX_W'($urandom) & sb.mask())
                                                   : INDEX_W'($urandom);
                push_load(idx, rand_word());
            end else if (pick < 23) begin
                push_carry(rand_word());
            end else if (pick < 80) begin
                br = t_branch'($urandom_range(0, 3));
                ra = ($urandom_range(0, 1) == 0) ? aim_addr(br) : $urandom;
                rb = ($urandom_range(0, 1) == 0) ? aim_addr(br) : $urandom;
                push_mix(br, ra, rb, rand_word(), rand_word());
            end else begin
                if ($urandom_range(0, 99) < 80)
                    idx = INDEX_W'(sb.loaded_list[$urandom_range(0, sb.loaded_list.size() - 1)]);
                else
                    idx = INDEX_W'($urandom) & sb.mask();
                push_read(idx);
            end
        end
    endtask

    localparam logic [SIZE_LOG2_W-1:0] SIZE_PLAN [9] = '{
        5'd0, 5'd1, 5'd4, 5'd17, 5'd31, 5'd2, 5'd9, 5'd18, 5'd6
    };

    localparam logic [INDEX_W-1:0] TOP_WORD = '1;
    localparam logic [INDEX_W-1:0] ODD_WORD = 17'h15555;
    localparam logic [INDEX_W-1:0] EVN_WORD = 17'h0aaaa;

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_LOAD;
        i_word_index   = '0;
        i_word_value   = '0;
        i_branch       = BR_ADD;
        i_addr_first   = '0;
        i_addr_second  = '0;
        i_value_first  = '0;
        i_value_second = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        sb             = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, run at the reset size.
        push_load('0, '0);
        push_load(TOP_WORD, '1);
        push_load(ODD_WORD, {32{2'b10}});
        push_load(EVN_WORD, {32{2'b01}});
        push_read('0);
        push_read(TOP_WORD);
        push_carry('1);
        push_mix(BR_ADD, 32'h0, $urandom, '1, rand_word());
        push_mix(BR_XOR, KEY_XOR ^ 32'h0001ffff, $urandom, '1, rand_word());
        push_carry(64'h0123456789abcdef);
        // Both pair addresses land on the same word.
        push_mix(BR_PAIR, KEY_PAIR ^ 32'h15555, KEY_PAIR ^ 32'h15555, rand_word(), '1);
        // The indirect target is the word itself, so the re-read sees the update.
        push_load(EVN_WORD, {$urandom, 15'h0, EVN_WORD});
        push_mix(BR_INDIRECT, KEY_INDIRECT ^ 32'h0aaaa, $urandom, '1, '0);
        push_read(EVN_WORD);
        push_read(ODD_WORD);
        push_read('0);
        push_read(TOP_WORD);
        push_mix(BR_INDIRECT, '1, '1, rand_word(), '1);
        push_mix(BR_ADD, '1, '0, '0, '1);
        push_mix(BR_PAIR, '0, '1, '1, '0);
        push_read(TOP_WORD);
        drain();

        foreach (SIZE_PLAN[ph]) begin
            write_size(SIZE_PLAN[ph]);
            quiet = (ph == 3);
            random_burst(BURST_ITEMS);
            drain();
            quiet = 1'b0;
        end

        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
